/* hw/rtl/hrc_pkg.sv */
// hrc_pkg: shared types and constants of the hsb/rgb color converter
`default_nettype none
package hrc_pkg;

  // direction codes
  localparam logic FUNC_HSB2RGB = 1'b0;
  localparam logic FUNC_RGB2HSB = 1'b1;

  // angles and percent scale
  localparam int unsigned HUE_FULL   = 360;
  localparam int unsigned HUE_SECTOR = 60;
  localparam int unsigned PCT_MAX    = 100;
  localparam int unsigned BYTE_MAX   = 255;

  // floor(p*255/100) == (p*1336965) >> 19 for p <= 100 (255 * ceil(2^19/100))
  localparam int unsigned PCT_TO_BYTE_MUL   = 1336965;
  localparam int unsigned PCT_TO_BYTE_SHIFT = 19;
  // floor(m*100/255) == (m*1644900) >> 22 for m <= 255 (100 * ceil(2^22/255))
  localparam int unsigned BYTE_TO_PCT_MUL   = 1644900;
  localparam int unsigned BYTE_TO_PCT_SHIFT = 22;
  // floor(x/60) == (x*17477) >> 20 for x <= 255*60 (ceil(2^20/60))
  localparam int unsigned DIV60_MUL   = 17477;
  localparam int unsigned DIV60_SHIFT = 20;

  // pipelined divider geometry: quotient known to fit, three bits per stage
  localparam int unsigned DIV_NUM_W  = 17;
  localparam int unsigned DIV_DEN_W  = 8;
  localparam int unsigned DIV_QUO_W  = 9;
  localparam int unsigned DIV_STEP_W = 3;

  // clock edges from accepted transaction to result strobe
  localparam int unsigned PIPE_LATENCY = 5;

  typedef struct packed {
    logic       func;
    logic [9:0] hue_in;
    logic [7:0] sat_in;
    logic [7:0] bri_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [8:0] hue_out;
    logic [6:0] sat_out;
    logic [6:0] bri_out;
  } out_item_t;

endpackage
`default_nettype wire

/* hw/rtl/hrc_div.sv */
// hrc_div: three-stage restoring divider, quotient must fit in DIV_QUO_W bits
`default_nettype none
module hrc_div (
  input  wire logic                               clk,
  input  wire logic [hrc_pkg::DIV_NUM_W-1:0]      num,
  input  wire logic [hrc_pkg::DIV_DEN_W-1:0]      den,
  output logic      [hrc_pkg::DIV_QUO_W-1:0]      quo
);

  localparam int unsigned DW = hrc_pkg::DIV_DEN_W;
  localparam int unsigned SW = hrc_pkg::DIV_STEP_W;
  localparam int unsigned QW = hrc_pkg::DIV_QUO_W;

  // a few restoring steps: returns {remainder, quotient bits}
  function automatic logic [DW+SW-1:0] div_steps(input logic [DW-1:0] rem_in,
                                                 input logic [DW-1:0] dv,
                                                 input logic [SW-1:0] bits);
    logic [DW:0]   t;
    logic [DW-1:0] rem;
    logic [SW-1:0] q;
    rem = rem_in;
    q   = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      t = {rem, bits[i]};
      if (t >= {1'b0, dv}) begin
        t = t - {1'b0, dv};
        q[i] = 1'b1;
      end
      rem = t[DW-1:0];
    end
    return {rem, q};
  endfunction

  logic [DW+SW-1:0] sa, sb, sc;
  logic [DW-1:0]    rem_a_r, rem_b_r;
  logic [DW-1:0]    den_a_r, den_b_r;
  logic [2*SW-1:0]  low_a_r;
  logic [SW-1:0]    low_b_r;
  logic [SW-1:0]    q_a_r;
  logic [2*SW-1:0]  q_b_r;
  logic [QW-1:0]    quo_r;

  // high numerator bits start as the partial remainder (below den by contract)
  assign sa = div_steps(num[QW+DW-1:QW], den, num[QW-1:QW-SW]);
  assign sb = div_steps(rem_a_r, den_a_r, low_a_r[2*SW-1:SW]);
  assign sc = div_steps(rem_b_r, den_b_r, low_b_r);

  always_ff @(posedge clk) begin
    rem_a_r <= sa[DW+SW-1:SW];
    q_a_r   <= sa[SW-1:0];
    den_a_r <= den;
    low_a_r <= num[2*SW-1:0];
    rem_b_r <= sb[DW+SW-1:SW];
    q_b_r   <= {q_a_r, sb[SW-1:0]};
    den_b_r <= den_a_r;
    low_b_r <= low_a_r[SW-1:0];
    quo_r   <= {q_b_r, sc[SW-1:0]};
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

/* hw/rtl/hsb_rgb_color_converter_top.sv */
// hsb_rgb_color_converter_top: pipelined hsb <-> rgb color converter
//
//   channel  ports                   handshake
//   -------  ----------------------  ---------------------------------------
//   input    start, busy, in_data    transaction taken when start && !busy
//   result   out_strobe, out_data    one-cycle strobe, receiver cannot stall
//
// one transaction per clock, every clock, once busy is low; results leave
// in the order their transactions were taken
// the rgb -> hsb path sets the pipeline depth: a 3-stage restoring divider for hue
// and saturation sits between an input stage and the output register
// synchronous active-low reset clears the valid bits; busy is high during
// reset and for the first cycle after it, and low from then on
// nothing ever stalls, so valid bits simply shift down the pipeline
`default_nettype none
module hsb_rgb_color_converter_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire hrc_pkg::in_item_t in_data,
  output logic                   out_strobe,
  output hrc_pkg::out_item_t     out_data
);

  // 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,  // red to yellow
    SEC_YG = 3'd1,  // yellow to green
    SEC_GC = 3'd2,  // green to cyan
    SEC_CB = 3'd3,  // cyan to blue
    SEC_BM = 3'd4,  // blue to magenta
    SEC_MR = 3'd5   // magenta to red
  } sector_t;

  localparam int unsigned NW = hrc_pkg::DIV_NUM_W;

  // ---------------------------------------------------------------------
  // control: busy and valid bits
  // ---------------------------------------------------------------------
  logic       busy_r;
  logic [4:1] v_r;
  logic       out_strobe_r;
  logic       take;

  assign take = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      v_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      v_r          <= {v_r[3:1], take};
      out_strobe_r <= v_r[4];
    end
  end

  // func travels with the data
  logic func1_r, func2_r, func3_r, func4_r;

  // ---------------------------------------------------------------------
  // stage 1: hue wrap and clamps / channel max, min and divider operands
  // ---------------------------------------------------------------------
  logic [8:0]  hmod1_nxt, hmod1_r;
  logic [6:0]  scl1_nxt, scl1_r, bcl1_nxt, bcl1_r;
  logic        sgray1_r;
  logic [7:0]  mx1_nxt, mx1_r, d1_nxt, d1_r;
  logic [NW-1:0] nhue1_nxt, nhue1_r, nsat1_nxt, nsat1_r;
  logic        neg1_nxt, neg1_r;

  always_comb begin
    logic [7:0] r, g, b, mn;
    logic       red_max, grn_max;
    r = in_data.red_in;
    g = in_data.green_in;
    b = in_data.blue_in;

    // hue modulo 360, input below three turns
    if (in_data.hue_in >= 10'(2 * hrc_pkg::HUE_FULL)) begin
      hmod1_nxt = 9'(in_data.hue_in - 10'(2 * hrc_pkg::HUE_FULL));
    end else if (in_data.hue_in >= 10'(hrc_pkg::HUE_FULL)) begin
      hmod1_nxt = 9'(in_data.hue_in - 10'(hrc_pkg::HUE_FULL));
    end else begin
      hmod1_nxt = 9'(in_data.hue_in);
    end
    scl1_nxt = (in_data.sat_in > 8'(hrc_pkg::PCT_MAX)) ? 7'(hrc_pkg::PCT_MAX)
                                                        : 7'(in_data.sat_in);
    bcl1_nxt = (in_data.bri_in > 8'(hrc_pkg::PCT_MAX)) ? 7'(hrc_pkg::PCT_MAX)
                                                        : 7'(in_data.bri_in);

    // red wins ties over green, green over blue
    red_max = (r >= g) && (r >= b);
    grn_max = !red_max && (g >= b);
    mx1_nxt = red_max ? r : (grn_max ? g : b);
    mn      = r;
    if (g < mn) begin
      mn = g;
    end
    if (b < mn) begin
      mn = b;
    end
    d1_nxt   = mx1_nxt - mn;
    neg1_nxt = red_max && (b > g);

    // hue numerator, quotient is the hue (or 360 minus it when negative)
    if (red_max) begin
      if (b > g) begin
        nhue1_nxt = NW'(60) * NW'(8'(b - g)) + NW'(d1_nxt) - NW'(1);
      end else begin
        nhue1_nxt = NW'(60) * NW'(8'(g - b));
      end
    end else if (grn_max) begin
      nhue1_nxt = NW'(120) * NW'(d1_nxt) + NW'(60) * NW'(b) - NW'(60) * NW'(r);
    end else begin
      nhue1_nxt = NW'(240) * NW'(d1_nxt) + NW'(60) * NW'(r) - NW'(60) * NW'(g);
    end
    nsat1_nxt = NW'(d1_nxt) * NW'(hrc_pkg::PCT_MAX);
  end

  always_ff @(posedge clk) begin
    func1_r  <= in_data.func;
    hmod1_r  <= hmod1_nxt;
    scl1_r   <= scl1_nxt;
    bcl1_r   <= bcl1_nxt;
    sgray1_r <= (in_data.sat_in == 8'd0);
    mx1_r    <= mx1_nxt;
    d1_r     <= d1_nxt;
    nhue1_r  <= nhue1_nxt;
    nsat1_r  <= nsat1_nxt;
    neg1_r   <= neg1_nxt;
  end

  // hue and saturation quotients, three stages each
  logic [hrc_pkg::DIV_QUO_W-1:0] qhue4, qsat4;

  hrc_div u_div_hue (
    .clk (clk),
    .num (nhue1_r),
    .den (d1_r),
    .quo (qhue4)
  );

  hrc_div u_div_sat (
    .clk (clk),
    .num (nsat1_r),
    .den (mx1_r),
    .quo (qsat4)
  );

  // ---------------------------------------------------------------------
  // stage 2: percent to byte scaling, sector split / brightness percent
  // ---------------------------------------------------------------------
  logic [27:0] vprod, sprod;
  logic [28:0] bprod;
  logic [7:0]  v2_r, s8_2_r;
  sector_t     sec2_nxt, sec2_r;
  logic [5:0]  pos2_nxt, pos2_r;
  logic        sgray2_r;
  logic [6:0]  bri2_r;
  logic        neg2_r, flat2_r;

  assign vprod = 28'(bcl1_r) * 28'(hrc_pkg::PCT_TO_BYTE_MUL);
  assign sprod = 28'(scl1_r) * 28'(hrc_pkg::PCT_TO_BYTE_MUL);
  assign bprod = 29'(mx1_r) * 29'(hrc_pkg::BYTE_TO_PCT_MUL);

  always_comb begin
    logic [8:0] sec_base;
    if (hmod1_r >= 9'(5 * hrc_pkg::HUE_SECTOR)) begin
      sec2_nxt = SEC_MR;
      sec_base = 9'(5 * hrc_pkg::HUE_SECTOR);
    end else if (hmod1_r >= 9'(4 * hrc_pkg::HUE_SECTOR)) begin
      sec2_nxt = SEC_BM;
      sec_base = 9'(4 * hrc_pkg::HUE_SECTOR);
    end else if (hmod1_r >= 9'(3 * hrc_pkg::HUE_SECTOR)) begin
      sec2_nxt = SEC_CB;
      sec_base = 9'(3 * hrc_pkg::HUE_SECTOR);
    end else if (hmod1_r >= 9'(2 * hrc_pkg::HUE_SECTOR)) begin
      sec2_nxt = SEC_GC;
      sec_base = 9'(2 * hrc_pkg::HUE_SECTOR);
    end else if (hmod1_r >= 9'(hrc_pkg::HUE_SECTOR)) begin
      sec2_nxt = SEC_YG;
      sec_base = 9'(hrc_pkg::HUE_SECTOR);
    end else begin
      sec2_nxt = SEC_RY;
      sec_base = '0;
    end
    // odd sectors ramp down, even sectors ramp up
    pos2_nxt = 6'(hmod1_r - sec_base);
    if (sec2_nxt[0]) begin
      pos2_nxt = 6'(hrc_pkg::HUE_SECTOR) - pos2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func2_r  <= func1_r;
    v2_r     <= 8'(vprod >> hrc_pkg::PCT_TO_BYTE_SHIFT);
    s8_2_r   <= 8'(sprod >> hrc_pkg::PCT_TO_BYTE_SHIFT);
    sec2_r   <= sec2_nxt;
    pos2_r   <= pos2_nxt;
    sgray2_r <= sgray1_r;
    bri2_r   <= 7'(bprod >> hrc_pkg::BYTE_TO_PCT_SHIFT);
    neg2_r   <= neg1_r;
    flat2_r  <= (d1_r == 8'd0);
  end

  // ---------------------------------------------------------------------
  // stage 3: base level of the two non-leading channels
  // ---------------------------------------------------------------------
  logic [15:0] base_prod;
  logic [7:0]  v3_r, base3_r;
  sector_t     sec3_r;
  logic [5:0]  pos3_r;
  logic        sgray3_r;
  logic [6:0]  bri3_r;
  logic        neg3_r, flat3_r;

  assign base_prod = 16'(8'(hrc_pkg::BYTE_MAX) - s8_2_r) * 16'(v2_r);

  always_ff @(posedge clk) begin
    func3_r  <= func2_r;
    v3_r     <= v2_r;
    base3_r  <= base_prod[15:8];
    sec3_r   <= sec2_r;
    pos3_r   <= pos2_r;
    sgray3_r <= sgray2_r;
    bri3_r   <= bri2_r;
    neg3_r   <= neg2_r;
    flat3_r  <= flat2_r;
  end

  // ---------------------------------------------------------------------
  // stage 4: ramp product
  // ---------------------------------------------------------------------
  logic [7:0]  v4_r, base4_r;
  sector_t     sec4_r;
  logic [13:0] prod4_r;
  logic        sgray4_r;
  logic [6:0]  bri4_r;
  logic        neg4_r, flat4_r;

  always_ff @(posedge clk) begin
    func4_r  <= func3_r;
    v4_r     <= v3_r;
    base4_r  <= base3_r;
    sec4_r   <= sec3_r;
    prod4_r  <= 14'(v3_r - base3_r) * 14'(pos3_r);
    sgray4_r <= sgray3_r;
    bri4_r   <= bri3_r;
    neg4_r   <= neg3_r;
    flat4_r  <= flat3_r;
  end

  // ---------------------------------------------------------------------
  // stage 5: channel assignment / hue fixup, output register
  // ---------------------------------------------------------------------
  logic [28:0]        lerp_prod;
  logic [7:0]         lerp;
  hrc_pkg::out_item_t res_nxt, out_data_r;

  assign lerp_prod = 29'(prod4_r) * 29'(hrc_pkg::DIV60_MUL);
  assign lerp      = 8'(lerp_prod >> hrc_pkg::DIV60_SHIFT) + base4_r;

  always_comb begin
    res_nxt = '0;
    if (func4_r == hrc_pkg::FUNC_RGB2HSB) begin
      // gray has no hue and no saturation
      if (flat4_r) begin
        res_nxt.hue_out = '0;
        res_nxt.sat_out = '0;
      end else begin
        res_nxt.hue_out = neg4_r ? (9'(hrc_pkg::HUE_FULL) - qhue4) : qhue4;
        res_nxt.sat_out = 7'(qsat4);
      end
      res_nxt.bri_out = bri4_r;
    end else if (sgray4_r) begin
      res_nxt.red_out   = v4_r;
      res_nxt.green_out = v4_r;
      res_nxt.blue_out  = v4_r;
    end else begin
      unique case (sec4_r)
        SEC_RY: begin
          res_nxt.red_out = v4_r;    res_nxt.green_out = lerp;  res_nxt.blue_out = base4_r;
        end
        SEC_YG: begin
          res_nxt.red_out = lerp;    res_nxt.green_out = v4_r;  res_nxt.blue_out = base4_r;
        end
        SEC_GC: begin
          res_nxt.red_out = base4_r; res_nxt.green_out = v4_r;  res_nxt.blue_out = lerp;
        end
        SEC_CB: begin
          res_nxt.red_out = base4_r; res_nxt.green_out = lerp;  res_nxt.blue_out = v4_r;
        end
        SEC_BM: begin
          res_nxt.red_out = lerp;    res_nxt.green_out = base4_r; res_nxt.blue_out = v4_r;
        end
        default: begin
          res_nxt.red_out = v4_r;    res_nxt.green_out = base4_r; res_nxt.blue_out = lerp;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= res_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
`default_nettype wire

/* hw/rtl/hrc_checker.sv */
// hrc_checker: port-level assertions for the color converter, bound to the top level
`default_nettype none
module hrc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire hrc_pkg::in_item_t  in_data,
  input wire logic               out_strobe,
  input wire hrc_pkg::out_item_t out_data
);

  // never holds off a transaction while rst_n and its $past value are both high
  a_no_busy: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  // every taken transaction yields a result after the pipeline depth
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(hrc_pkg::PIPE_LATENCY) out_strobe)
    else $error("result missing for taken transaction");

  // no result without a transaction taken at the matching edge
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, hrc_pkg::PIPE_LATENCY))
    else $error("result without transaction");

  // hsb results stay in range
  a_hsb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.hue_out < 9'(hrc_pkg::HUE_FULL) &&
                   out_data.sat_out <= 7'(hrc_pkg::PCT_MAX) &&
                   out_data.bri_out <= 7'(hrc_pkg::PCT_MAX))
    else $error("hsb result out of range");

  // fields of the other direction read zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      (($past(in_data.func, hrc_pkg::PIPE_LATENCY) == hrc_pkg::FUNC_RGB2HSB) &&
       out_data.red_out == 8'd0 && out_data.green_out == 8'd0 &&
       out_data.blue_out == 8'd0) ||
      (($past(in_data.func, hrc_pkg::PIPE_LATENCY) == hrc_pkg::FUNC_HSB2RGB) &&
       out_data.hue_out == 9'd0 && out_data.sat_out == 7'd0 &&
       out_data.bri_out == 7'd0))
    else $error("unused result fields not zero");

endmodule

bind hsb_rgb_color_converter_top hrc_checker u_hrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
`default_nettype wire
